// ===== hw/rtl/lphs_pkg.sv =====
// ---------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear probing hash set.
// ---------------------------------------------------------------------------
package lphs_pkg;

  localparam int SLOTS  = 1024;
  localparam int ADDR_W = $clog2(SLOTS);
  localparam int CNT_W  = 11;
  localparam int KEY_W  = 32;
  localparam int BIT_W  = $clog2(KEY_W);
  localparam int ENT_W  = KEY_W + 2;

  localparam logic [CNT_W-1:0] SIZE_RESET = CNT_W'(193);

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_REMOVE = 2'd1;

  localparam logic [1:0] SL_EMPTY = 2'd0;
  localparam logic [1:0] SL_USED  = 2'd1;
  localparam logic [1:0] SL_TOMB  = 2'd2;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_REMOVED = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;
  localparam logic [2:0] ST_FOUND   = 3'd5;

  typedef struct packed {
    logic clr_write;
    logic load;
    logic mod_step;
    logic check;
    logic write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic skip;
    logic mod_last;
    logic chk_write;
    logic chk_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== hw/rtl/linear_probe_hash_set.sv =====
// ---------------------------------------------------------------------------
// linear_probe_hash_set
// Open-addressing set of 32-bit keys with linear probing and tombstones.
//
//   channel  handshake             word
//   in       in_valid / in_stall   func, key
//   out      out_valid / out_stall status, entry_count
//   cfg      cfg_we                cfg_data (table_slots_used)
//
// An item passes an accept state, a bit-serial modulo over the key bits, a
// read and a check state per probed slot (RAM read latency), a write state
// when the table changes and an output state; an insert refused at one-third
// load skips the modulo and the probe.
// After reset and after each cfg write a clearing pass sweeps the slot RAM
// with in_stall high. The output word holds under out_stall.
// ---------------------------------------------------------------------------
module linear_probe_hash_set (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lphs_pkg::CNT_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 func,
  input  logic [lphs_pkg::KEY_W-1:0] key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [lphs_pkg::CNT_W-1:0] entry_count
);
  import lphs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lphs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  lphs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .func        (func),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

// ===== hw/rtl/lphs_ram.sv =====
// ---------------------------------------------------------------------------
// lphs_ram
// Single-port RAM with registered read.
// ---------------------------------------------------------------------------
module lphs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hw/rtl/lphs_ctrl.sv =====
// ---------------------------------------------------------------------------
// lphs_ctrl
// Sequencer: clear sweep, modulo iterations, probe loop, write, output.
// ---------------------------------------------------------------------------
module lphs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           in_valid,
  output logic           in_stall,
  output lphs_pkg::cmd_t cmd,
  input  lphs_pkg::sts_t sts
);
  import lphs_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_READ  = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        if (sts.skip) begin
          state_next = S_DONE;
        end else begin
          cmd.mod_step = 1'b1;
          if (sts.mod_last) state_next = S_READ;
        end
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_write) state_next = S_WRITE;
        else if (sts.chk_done) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_WRITE: begin
        cmd.write = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) state_next = S_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

endmodule

// ===== hw/rtl/lphs_dp.sv =====
// ---------------------------------------------------------------------------
// lphs_dp
// Datapath: size register, bit-serial modulo, probe registers, slot RAM,
// key count and output word.
// ---------------------------------------------------------------------------
module lphs_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [lphs_pkg::CNT_W-1:0]  cfg_data,
  input  logic [1:0]                  func,
  input  logic [lphs_pkg::KEY_W-1:0]  key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  status,
  output logic [lphs_pkg::CNT_W-1:0]  entry_count,
  input  lphs_pkg::cmd_t              cmd,
  output lphs_pkg::sts_t              sts
);
  import lphs_pkg::*;

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  key_count;
  logic [ADDR_W-1:0] clr_addr;
  logic [1:0]        func_r;
  logic [KEY_W-1:0]  key_r;
  logic [BIT_W-1:0]  bitcnt;
  logic [ADDR_W-1:0] rem;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  n;
  logic              have_tomb;
  logic [ADDR_W-1:0] tomb;
  logic              skip;
  logic [2:0]        res;
  logic [ADDR_W-1:0] wr_addr;
  logic [1:0]        wr_state;
  logic              wr_inc;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  logic [CNT_W-1:0]  size_clamp;
  logic [CNT_W+1:0]  load3;
  logic [ADDR_W:0]   r2;
  logic [ADDR_W-1:0] rem_next;
  logic [1:0]        sl;
  logic              match;
  logic              last;
  logic [ADDR_W-1:0] idx_next;
  logic              chk_write;
  logic              chk_done;
  logic [2:0]        chk_res;
  logic [ADDR_W-1:0] chk_addr;
  logic [1:0]        chk_state;
  logic              chk_inc;
  logic              insert;

  lphs_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = cmd.clr_write | cmd.write;
    ram_addr  = idx;
    ram_wdata = {wr_state, key_r};
    if (cmd.clr_write) begin
      ram_addr  = clr_addr;
      ram_wdata = {SL_EMPTY, KEY_W'(0)};
    end else if (cmd.write) begin
      ram_addr = wr_addr;
    end
  end

  always_comb begin
    if (cfg_data == '0) size_clamp = CNT_W'(1);
    else if (cfg_data > CNT_W'(SLOTS)) size_clamp = CNT_W'(SLOTS);
    else size_clamp = cfg_data;
  end

  assign insert = (func_r == FN_INSERT);
  assign load3  = {2'b0, key_count} + {1'b0, key_count, 1'b0};

  assign r2       = {rem, key_r[~bitcnt]};
  assign rem_next = (CNT_W'(r2) >= size) ? ADDR_W'(CNT_W'(r2) - size) : ADDR_W'(r2);

  assign sl       = ram_rdata[ENT_W-1 -: 2];
  assign match    = (sl == SL_USED) && (ram_rdata[KEY_W-1:0] == key_r);
  assign last     = (n + CNT_W'(1)) == size;
  assign idx_next = ((CNT_W'(idx) + CNT_W'(1)) == size) ? '0 : idx + ADDR_W'(1);

  always_comb begin
    chk_write = 1'b0;
    chk_done  = 1'b0;
    chk_res   = ST_ABSENT;
    chk_addr  = have_tomb ? tomb : idx;
    chk_state = SL_USED;
    chk_inc   = 1'b1;
    if (sl == SL_EMPTY) begin
      if (insert) begin
        chk_write = 1'b1;
        chk_res   = ST_ADDED;
      end else begin
        chk_done = 1'b1;
      end
    end else if (match) begin
      case (func_r)
        FN_INSERT: begin
          chk_done = 1'b1;
          chk_res  = ST_PRESENT;
        end
        FN_REMOVE: begin
          chk_write = 1'b1;
          chk_res   = ST_REMOVED;
          chk_addr  = idx;
          chk_state = SL_TOMB;
          chk_inc   = 1'b0;
        end
        default: begin
          chk_done = 1'b1;
          chk_res  = ST_FOUND;
        end
      endcase
    end else if (last) begin
      if (insert && (have_tomb || sl == SL_TOMB)) begin
        chk_write = 1'b1;
        chk_res   = ST_ADDED;
      end else begin
        chk_done = 1'b1;
        chk_res  = insert ? ST_FULL : ST_ABSENT;
      end
    end
  end

  always_comb begin
    sts.clr_last  = (clr_addr == ADDR_W'(SLOTS - 1));
    sts.skip      = skip;
    sts.mod_last  = (bitcnt == BIT_W'(KEY_W - 1));
    sts.chk_write = chk_write;
    sts.chk_done  = chk_done;
    sts.out_busy  = out_valid & out_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= SIZE_RESET;
      key_count <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        size      <= size_clamp;
        key_count <= '0;
        clr_addr  <= '0;
      end else if (cmd.clr_write) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.write && !cfg_we) begin
        if (wr_inc) key_count <= key_count + CNT_W'(1);
        else if (key_count != '0) key_count <= key_count - CNT_W'(1);
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r    <= func;
      key_r     <= key;
      bitcnt    <= '0;
      rem       <= '0;
      n         <= '0;
      have_tomb <= 1'b0;
      skip      <= (func == FN_INSERT) && (load3 >= {2'b0, size});
      res       <= ST_FULL;
    end
    if (cmd.mod_step) begin
      bitcnt <= bitcnt + BIT_W'(1);
      rem    <= rem_next;
      idx    <= rem_next;
    end
    if (cmd.check) begin
      res      <= chk_res;
      wr_addr  <= chk_addr;
      wr_state <= chk_state;
      wr_inc   <= chk_inc;
      n        <= n + CNT_W'(1);
      idx      <= idx_next;
      if (sl == SL_TOMB && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb      <= idx;
      end
    end
    if (cmd.emit) begin
      status      <= res;
      entry_count <= key_count;
    end
  end

endmodule

// ===== bench/linear_probe_hash_set_tb.sv =====
// ---------------------------------------------------------------------------
// linear_probe_hash_set_tb
// Self-checking bench for the linear probing hash set. A queue of insert,
// remove and query words, table size writes and drain points feeds a
// clocked driver. The driver predicts status and entry count per accepted
// word. A clocked monitor compares each output word in order, with random
// stall bursts and one long hold to back up the input.
// ---------------------------------------------------------------------------
module linear_probe_hash_set_tb;
  import lphs_pkg::*;

  localparam logic [1:0] FN_QUERY = 2'd2;
  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam int HANG_LIMIT = 20000;
  localparam int LONG_HOLD  = 400;

  typedef enum logic [1:0] {K_WORD, K_CFG, K_DRAIN} kind_t;

  typedef struct {
    kind_t            kind;
    logic [1:0]       fn;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] sz;
  } pend_t;

  typedef struct {
    logic [2:0]       st;
    logic [CNT_W-1:0] cnt;
  } reply_t;

  logic             clk, rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;
  logic             in_valid, in_stall;
  logic [1:0]       func;
  logic [KEY_W-1:0] key;
  logic             out_valid, out_stall;
  logic [2:0]       status;
  logic [CNT_W-1:0] entry_count;

  pend_t  pending[$];
  reply_t replies_due[$];

  logic [KEY_W-1:0] set_key [SLOTS];
  logic [1:0]       set_slot[SLOTS];
  int               set_count;
  int               set_size;

  int errors, idle_cycles, accepted_words, settle;
  int send_gap, recv_hold;
  bit long_done;

  linear_probe_hash_set u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .key(key),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .entry_count(entry_count)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic void set_clear(input logic [CNT_W-1:0] v);
    for (int i = 0; i < SLOTS; i++) set_slot[i] = SL_EMPTY;
    set_count = 0;
    set_size = (v == 0) ? 1 : ((v > SLOTS) ? SLOTS : int'(v));
  endfunction

  function automatic int set_find(input logic [KEY_W-1:0] k);
    int idx;
    idx = int'(k % set_size);
    for (int n = 0; n < set_size; n++) begin
      if (set_slot[idx] == SL_EMPTY) return -1;
      if (set_slot[idx] == SL_USED && set_key[idx] == k) return idx;
      idx = (idx + 1 == set_size) ? 0 : idx + 1;
    end
    return -1;
  endfunction

  function automatic reply_t set_apply(input logic [1:0] fn, input logic [KEY_W-1:0] k);
    reply_t r;
    int idx, tomb, pos;
    bit got_empty;
    r.st = ST_FOUND;
    if (fn == FN_INSERT) begin
      tomb = -1;
      got_empty = 0;
      idx = int'(k % set_size);
      r.st = ST_FULL;
      if (set_count * 3 < set_size) begin
        r.st = ST_ADDED;
        for (int n = 0; n < set_size; n++) begin
          if (set_slot[idx] == SL_EMPTY) begin
            got_empty = 1;
            break;
          end
          if (set_slot[idx] == SL_USED) begin
            if (set_key[idx] == k) begin
              r.st = ST_PRESENT;
              break;
            end
          end else if (tomb < 0) begin
            tomb = idx;
          end
          idx = (idx + 1 == set_size) ? 0 : idx + 1;
        end
        if (r.st == ST_ADDED) begin
          if (tomb >= 0) idx = tomb;
          if (tomb >= 0 || got_empty) begin
            set_key[idx] = k;
            set_slot[idx] = SL_USED;
            set_count = (set_count + 1) & 11'h7ff;
          end else begin
            r.st = ST_FULL;
          end
        end
      end
    end else begin
      pos = set_find(k);
      if (fn == FN_REMOVE) begin
        r.st = ST_ABSENT;
        if (pos >= 0) begin
          set_slot[pos] = SL_TOMB;
          if (set_count > 0) set_count--;
          r.st = ST_REMOVED;
        end
      end else begin
        r.st = (pos >= 0) ? ST_FOUND : ST_ABSENT;
      end
    end
    r.cnt = CNT_W'(set_count);
    return r;
  endfunction

  task automatic add_word(input logic [1:0] fn, input logic [KEY_W-1:0] k);
    pend_t p;
    p.kind = K_WORD;
    p.fn = fn;
    p.k = k;
    p.sz = '0;
    pending.push_back(p);
  endtask

  task automatic add_mark(input kind_t kd, input logic [CNT_W-1:0] v);
    pend_t p;
    p.kind = kd;
    p.fn = FN_QUERY;
    p.k = '0;
    p.sz = v;
    pending.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    reply_t r;
    pend_t  p;
    logic nxt_valid, nxt_we;
    if (rst) begin
      in_valid <= 1'b0;
      cfg_we <= 1'b0;
      settle = 0;
      send_gap = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_we = 1'b0;
      if (in_valid && !in_stall) begin
        r = set_apply(func, key);
        replies_due.push_back(r);
        accepted_words++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (replies_due.size() == 0 && !in_valid) settle++;
        else settle = 0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending.size() > 0) begin
          p = pending[0];
          if (p.kind == K_WORD) begin
            void'(pending.pop_front());
            func <= p.fn;
            key <= p.k;
            nxt_valid = 1'b1;
            if (pending.size() > 150 && $urandom_range(0, 9) == 0)
              send_gap = $urandom_range(1, 7);
          end else if (settle >= 50) begin
            void'(pending.pop_front());
            settle = 0;
            if (p.kind == K_CFG) begin
              nxt_we = 1'b1;
              cfg_data <= p.sz;
              set_clear(p.sz);
            end
          end
        end
      end
      in_valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t r;
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (replies_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: status %0d count %0d", status, entry_count);
        end else begin
          r = replies_due.pop_front();
          if (status !== r.st || entry_count !== r.cnt) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                       r.st, status, r.cnt, entry_count);
          end
        end
      end else if (in_valid && !in_stall) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= HANG_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
      end else if (!long_done && accepted_words > 400) begin
        long_done = 1;
        recv_hold = LONG_HOLD;
      end else if (pending.size() > 150 && $urandom_range(0, 9) == 0) begin
        recv_hold = $urandom_range(1, 7);
      end
      out_stall <= (recv_hold > 0);
    end
  end

  initial begin
    logic [KEY_W-1:0] pool[16];
    logic [CNT_W-1:0] sizes[8];
    logic [1:0] fn;
    int sz;
    errors = 0;
    idle_cycles = 0;
    accepted_words = 0;
    long_done = 0;
    rst = 1;
    in_valid = 0;
    cfg_we = 0;
    cfg_data = '0;
    func = '0;
    key = '0;
    out_stall = 0;
    set_clear(SIZE_RESET);

    add_word(FN_INSERT, 32'd10);
    add_word(FN_QUERY, 32'd10);
    add_mark(K_CFG, 11'd7);
    add_word(FN_INSERT, 32'd10);
    add_word(FN_INSERT, 32'd10);
    add_word(FN_INSERT, 32'd17);
    add_word(FN_REMOVE, 32'd10);
    add_word(FN_QUERY, 32'd17);
    add_word(FN_INSERT, 32'd24);
    add_word(FN_INSERT, 32'd3);
    add_word(FN_INSERT, 32'd31);
    add_word(FN_INSERT, 32'd17);
    add_word(FN_REMOVE, 32'd99);
    add_word(FN_SPARE, 32'd3);
    add_word(FN_QUERY, 32'hffff_ffff);
    add_mark(K_CFG, 11'd0);
    add_word(FN_INSERT, 32'hffff_ffff);
    add_word(FN_INSERT, 32'd5);
    add_word(FN_REMOVE, 32'hffff_ffff);
    add_word(FN_INSERT, 32'd0);
    add_mark(K_CFG, 11'h7ff);
    add_word(FN_INSERT, 32'hffff_ffff);
    add_word(FN_INSERT, 32'd1023);
    add_word(FN_QUERY, 32'd0);

    sizes = '{11'd1024, 11'd1, 11'd4, 11'd13, 11'd64, 11'd193, 11'h7ff, 11'd0};
    for (int ph = 0; ph < 8; ph++) begin
      sz = (ph == 7) ? $urandom_range(2, 1024) : int'(sizes[ph]);
      add_mark(K_CFG, CNT_W'(sz));
      for (int i = 0; i < 16; i++)
        pool[i] = ($urandom_range(0, 3) == 0) ? $urandom :
                  $urandom_range(0, 5) * sz + $urandom_range(0, 3);
      for (int i = 0; i < 195; i++) begin
        fn = ($urandom_range(0, 2) == 0) ? FN_INSERT : 2'($urandom_range(0, 3));
        add_word(fn, ($urandom_range(0, 7) == 0) ? $urandom : pool[$urandom_range(0, 15)]);
        if ($urandom_range(0, 99) == 0) add_mark(K_DRAIN, '0);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 0;
    wait (pending.size() == 0 && !in_valid && replies_due.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_ram.sv
hw/rtl/lphs_ctrl.sv
hw/rtl/lphs_dp.sv
hw/rtl/linear_probe_hash_set.sv
bench/linear_probe_hash_set_tb.sv
